### rtl/mmacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmacc_pkg: shared types, codes and microcode for the modulation matrix
// Holds the item and control structs, operation and condition codes, and
// the read-only control store that sequences one item.
// ----------------------------------------------------------------------------
package mmacc_pkg;

  // Destination table size
  localparam int NUM_DESTS = 16;
  localparam int DEST_AW   = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
  localparam int VALUE_W   = 14;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd16383;

  // Item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ROUTE = 2'd1;

  // Datapath operations
  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_WHEEL     = 3'd1;
  localparam logic [2:0] OP_ADD_MUL   = 3'd2;
  localparam logic [2:0] OP_ADD_CLIP  = 3'd3;
  localparam logic [2:0] OP_VCA_PREP  = 3'd4;
  localparam logic [2:0] OP_VCA_BLEND = 3'd5;
  localparam logic [2:0] OP_VCA_SCALE = 3'd6;
  localparam logic [2:0] OP_FIN       = 3'd7;

  // Jump conditions
  localparam logic [1:0] C_NEXT      = 2'd0;
  localparam logic [1:0] C_ALWAYS    = 2'd1;
  localparam logic [1:0] C_NOT_ROUTE = 2'd2;
  localparam logic [1:0] C_IS_VCA    = 2'd3;

  // Program steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_ENTRY = 3'd0;
  localparam logic [STEP_W-1:0] STEP_VPREP = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FIN   = 3'd6;

  // Magnitude at which the VCA source is used unblended
  localparam logic [5:0] MAG_FULL = 6'd63;
  // 255 * 255, base of the blend toward full scale
  localparam logic [15:0] BLEND_BASE = 16'd65025;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         dest_index;
    logic [13:0]        load_value;
    logic [7:0]         mod_source;
    logic               ac_coupled;
    logic signed [6:0]  amount;
    logic               scale_by_wheel;
    logic [7:0]         wheel;
  } item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } cw_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fire;
  } ctl_t;

  typedef struct packed {
    logic route;
    logic vca;
  } stat_t;

  // Control store: one word per step
  function automatic cw_t ucode_rom(input logic [STEP_W-1:0] step);
    cw_t cw;
    case (step)
      3'd0: cw = '{op: OP_WHEEL,     cond: C_NOT_ROUTE, target: STEP_FIN,   last: 1'b0};
      3'd1: cw = '{op: OP_ADD_MUL,   cond: C_IS_VCA,    target: STEP_VPREP, last: 1'b0};
      3'd2: cw = '{op: OP_ADD_CLIP,  cond: C_ALWAYS,    target: STEP_FIN,   last: 1'b0};
      3'd3: cw = '{op: OP_VCA_PREP,  cond: C_NEXT,      target: STEP_ENTRY, last: 1'b0};
      3'd4: cw = '{op: OP_VCA_BLEND, cond: C_NEXT,      target: STEP_ENTRY, last: 1'b0};
      3'd5: cw = '{op: OP_VCA_SCALE, cond: C_NEXT,      target: STEP_ENTRY, last: 1'b0};
      3'd6: cw = '{op: OP_FIN,       cond: C_NEXT,      target: STEP_ENTRY, last: 1'b1};
      default: cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_FIN,   last: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

### rtl/modulation_matrix_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulation_matrix_accumulator_unit: microcoded modulation matrix engine
// Loads, routes into and reads back a table of destination values and a
// multiplicative VCA level, one item at a time.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | mode, dest, load, source, amount
//   out_    | output    | out_valid/out_stall| result_value, is_vca
//   cfg_    | input     | cfg_valid/cfg_ready| vca_dest
//
// An accepted item keeps the input stalled through its steps: wheel, then
// multiply and add-clip on an additive routing or multiply, VCA prep, blend
// and scale on a VCA routing (neither on a load or read), then final. Steps
// run one per cycle on one shared multiplier; a stalled output holds the
// sequencer in its final step. The result is presented on the next cycle,
// which can also take a new item, even while a finished result waits. Reset
// clears the sequencer, the output valid and vca_dest and holds the input
// stalled; table entries and the VCA level hold garbage until loaded.
// ----------------------------------------------------------------------------
module modulation_matrix_accumulator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [3:0]          in_dest_index,
  input  logic [13:0]         in_load_value,
  input  logic [7:0]          in_mod_source,
  input  logic                in_ac_coupled,
  input  logic signed [6:0]   in_amount,
  input  logic                in_scale_by_wheel,
  input  logic [7:0]          in_wheel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [13:0]         out_result_value,
  output logic                out_is_vca,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_vca_dest
);
  import mmacc_pkg::*;

  logic                busy_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_result_r;
  logic                out_is_vca_r;
  logic [3:0]          vca_dest_r;

  cw_t                 cw;
  ctl_t                ctl;
  stat_t               stat;
  item_t               item_in;
  logic [VALUE_W-1:0]  fin_value;
  logic                accept;
  logic                fire;
  logic                take;
  logic [STEP_W-1:0]   step_nxt;

  assign in_stall  = busy_r || !rst_n;
  assign cfg_ready = !busy_r && rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_is_vca = out_is_vca_r;

  assign item_in = '{mode: in_mode, dest_index: in_dest_index, load_value: in_load_value,
                     mod_source: in_mod_source, ac_coupled: in_ac_coupled,
                     amount: in_amount, scale_by_wheel: in_scale_by_wheel,
                     wheel: in_wheel};

  // Fetch the control word; hold the final step while the output is full
  assign cw   = ucode_rom(step_r);
  assign fire = busy_r && !(cw.last && out_valid_r && out_stall);
  assign ctl  = '{op: cw.op, fire: fire};

  // Resolve the jump condition
  always_comb begin
    case (cw.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_ROUTE: take = !stat.route;
      C_IS_VCA:    take = stat.vca;
      default:     take = 1'b0;
    endcase
    step_nxt = take ? cw.target : step_r + 1'b1;
  end

  mmacc_datapath u_datapath (
    .clk       (clk),
    .item_load (accept),
    .item_in   (item_in),
    .ctl       (ctl),
    .vca_dest  (vca_dest_r),
    .stat      (stat),
    .fin_value (fin_value)
  );

  // Sequencer, output valid and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_ENTRY;
      out_valid_r <= 1'b0;
      vca_dest_r  <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        step_r <= STEP_ENTRY;
      end else if (fire) begin
        if (cw.last) begin
          busy_r <= 1'b0;
          step_r <= STEP_ENTRY;
        end else begin
          step_r <= step_nxt;
        end
      end
      if (fire && cw.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        vca_dest_r <= cfg_vca_dest;
      end
    end
  end

  // Capture the result on the final step
  always_ff @(posedge clk) begin
    if (fire && cw.last) begin
      out_result_r <= fin_value;
      out_is_vca_r <= stat.vca;
    end
  end

  // The program counter rests at entry whenever the sequencer is idle
  a_idle_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == STEP_ENTRY)
    else $error("sequencer idle away from entry step");

  // The final step always hands a result to the output register
  a_fin_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cw.last |=> out_valid_r && !busy_r)
    else $error("final step did not produce a result");

  // The program never runs past its final step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= STEP_FIN)
    else $error("step counter beyond program");

  // A VCA result is an 8-bit level
  a_vca_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_vca_r |-> out_result_r[13:8] == 6'd0)
    else $error("VCA result exceeds 8 bits");

endmodule

### rtl/mmacc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmacc_datapath: shared multiplier, destination table and VCA level
// Executes one microcode operation per cycle, when fired, on the latched item.
// ----------------------------------------------------------------------------
module mmacc_datapath (
  input  logic                         clk,
  input  logic                         item_load,
  input  mmacc_pkg::item_t             item_in,
  input  mmacc_pkg::ctl_t              ctl,
  input  logic [3:0]                   vca_dest,
  output mmacc_pkg::stat_t             stat,
  output logic [mmacc_pkg::VALUE_W-1:0] fin_value
);
  import mmacc_pkg::*;

  item_t               item_r;
  logic signed [6:0]   amt_r;
  logic signed [19:0]  acc_r;
  logic [7:0]          src_r;
  logic [7:0]          vca_r;
  logic [VALUE_W-1:0]  dest_r [NUM_DESTS];

  logic signed [9:0]   mul_a;
  logic signed [9:0]   mul_b;
  logic signed [19:0]  prod;
  logic                is_vca;
  logic                in_table;
  logic [DEST_AW-1:0]  addr;
  logic [VALUE_W-1:0]  dest_rd;
  logic [6:0]          amt_abs;
  logic [5:0]          mag;
  logic [7:0]          src_inv;
  logic signed [9:0]   src_dir;
  logic signed [20:0]  sum;
  logic [VALUE_W-1:0]  clip_val;
  logic [15:0]         blend;
  logic                tbl_we;
  logic [VALUE_W-1:0]  tbl_wdata;

  // Decode the addressed destination
  assign is_vca   = (item_r.dest_index == vca_dest);
  assign in_table = ({3'b000, item_r.dest_index} < 7'(NUM_DESTS));
  assign addr     = DEST_AW'(item_r.dest_index);
  assign dest_rd  = dest_r[addr];
  assign stat     = '{route: (item_r.mode == MODE_ROUTE), vca: is_vca};

  // VCA source shaping: invert for negative amounts, saturate magnitude
  assign amt_abs = amt_r[6] ? 7'(-amt_r) : amt_r;
  assign mag     = amt_abs[6] ? MAG_FULL : amt_abs[5:0];
  assign src_inv = amt_r[6] ? ~item_r.mod_source : item_r.mod_source;
  assign src_dir = item_r.ac_coupled ? ($signed({2'b00, item_r.mod_source}) - 10'sd128)
                                     : $signed({2'b00, item_r.mod_source});
  assign blend   = BLEND_BASE - acc_r[15:0];

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_WHEEL: begin
        mul_a = 10'(item_r.amount);
        mul_b = $signed({2'b00, item_r.wheel});
      end
      OP_ADD_MUL: begin
        mul_a = 10'(amt_r);
        mul_b = src_dir;
      end
      OP_VCA_PREP: begin
        mul_a = $signed({2'b00, mag, 2'b00});
        mul_b = $signed({2'b00, ~src_inv});
      end
      OP_VCA_SCALE: begin
        mul_a = $signed({2'b00, vca_r});
        mul_b = $signed({2'b00, src_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Accumulate into the destination and clip to the value range
  always_comb begin
    sum = 21'($signed({1'b0, dest_rd})) + 21'(acc_r);
    if (sum < 0) begin
      clip_val = '0;
    end else if (sum > 21'sd16383) begin
      clip_val = VALUE_MAX;
    end else begin
      clip_val = sum[VALUE_W-1:0];
    end
  end

  // Table write port
  always_comb begin
    tbl_we    = 1'b0;
    tbl_wdata = clip_val;
    if (ctl.fire && in_table && !is_vca) begin
      if (ctl.op == OP_ADD_CLIP) begin
        tbl_we = 1'b1;
      end else if (ctl.op == OP_FIN && item_r.mode == MODE_LOAD) begin
        tbl_we    = 1'b1;
        tbl_wdata = item_r.load_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      dest_r[addr] <= tbl_wdata;
    end
  end

  // Latch the item and run the working registers
  always_ff @(posedge clk) begin
    if (item_load) begin
      item_r <= item_in;
    end
    if (ctl.fire) begin
      case (ctl.op)
        OP_WHEEL: begin
          amt_r <= item_r.scale_by_wheel ? prod[14:8] : item_r.amount;
        end
        OP_ADD_MUL: begin
          acc_r <= prod;
        end
        OP_VCA_PREP: begin
          acc_r <= prod;
          src_r <= src_inv;
        end
        OP_VCA_BLEND: begin
          if (mag != MAG_FULL) begin
            src_r <= blend[15:8];
          end
        end
        OP_VCA_SCALE: begin
          vca_r <= prod[15:8];
        end
        OP_FIN: begin
          if (is_vca && item_r.mode == MODE_LOAD) begin
            vca_r <= item_r.load_value[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the item, valid during the final step
  always_comb begin
    if (item_r.mode == MODE_LOAD) begin
      fin_value = is_vca ? {6'b0, item_r.load_value[7:0]}
                         : (in_table ? item_r.load_value : '0);
    end else begin
      fin_value = is_vca ? {6'b0, vca_r} : (in_table ? dest_rd : '0);
    end
  end

endmodule
